@@ design/afr_pkg.sv @@
// shared types and constants for the addressed frame receiver
`default_nettype none

package afr_pkg;

    // register indexes on the config port
    localparam logic [1:0] REG_START_BYTE  = 2'd0;
    localparam logic [1:0] REG_OWN_ADDRESS = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_LEN = 2'd2;

    localparam logic [7:0] RST_START_BYTE  = 8'd126;
    localparam logic [7:0] RST_OWN_ADDRESS = 8'd0;
    localparam logic [5:0] RST_PAYLOAD_LEN = 6'd8;

    // result status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] own_address;
        logic [5:0] payload_length;
    } t_cfg;

    typedef struct packed {
        logic frame_start;
        logic store;
        logic burst_start;
        logic rd;
        logic load_byte;
        logic load_err;
        logic clr_frame;
    } t_cmd;

    typedef struct packed {
        logic start_match;
        logic addr_match;
        logic sum_match;
        logic len_zero;
        logic data_done;
        logic count_zero;
        logic last_rd;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ design/addressed_frame_receiver_top.sv @@
// top level of the addressed frame receiver
`default_nettype none

// Receives link bytes and deframes start-byte / address / payload / checksum frames.
// One received byte is taken per clock while a frame is being parsed. After a checksum
// byte that matches, the receiver stops taking bytes and plays out the N buffered payload
// bytes one by one (a payload buffer read with registered data, then a load of the result
// register, which waits while the output stalls); a mismatch gives one error transaction
// once the result register is free. The result register lets the next frame be received
// while the last result still waits. Registers: start byte at 0x0, own address at 0x4,
// payload length at 0x8 (saturated to MAX_PAYLOAD).
module addressed_frame_receiver_top
    import afr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [7:0]       o_payload_byte,
    output logic [4:0]       o_byte_index,
    output logic             o_last,
    output logic             o_status
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    afr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    afr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_sts      (sts),
        .o_rx_ready (o_rx_ready),
        .o_cmd      (cmd)
    );

    afr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .i_res_ready    (i_res_ready),
        .o_sts          (sts),
        .o_res_valid    (o_res_valid),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last         (o_last),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

@@ design/afr_regs.sv @@
// apb configuration registers
`default_nettype none

module afr_regs
    import afr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte     <= RST_START_BYTE;
            r_cfg.own_address    <= RST_OWN_ADDRESS;
            r_cfg.payload_length <= RST_PAYLOAD_LEN;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START_BYTE:  r_cfg.start_byte     <= pwdata[7:0];
                REG_OWN_ADDRESS: r_cfg.own_address    <= pwdata[7:0];
                REG_PAYLOAD_LEN: r_cfg.payload_length <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_BYTE:  prdata = {24'd0, r_cfg.start_byte};
            REG_OWN_ADDRESS: prdata = {24'd0, r_cfg.own_address};
            REG_PAYLOAD_LEN: prdata = {26'd0, r_cfg.payload_length};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ design/afr_dp.sv @@
// datapath: running sum, byte count, payload buffer and result register
`default_nettype none

module afr_dp
    import afr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_res_ready,
    output t_sts            o_sts,
    output logic            o_res_valid,
    output logic [7:0]      o_payload_byte,
    output logic [4:0]      o_byte_index,
    output logic            o_last,
    output logic            o_status
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [6:0] MAX7 = 7'(MAX_PAYLOAD);

    logic [7:0]    r_mem [MAX_PAYLOAD];
    logic [7:0]    r_rd_data;
    logic [7:0]    r_sum;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_burst_idx;

    logic          r_out_valid;
    logic [7:0]    r_payload;
    logic [4:0]    r_index;
    logic          r_last;
    logic          r_status;

    logic [6:0]    len7;
    logic [CW-1:0] eff_len;
    logic          store_ok;
    logic          do_store;
    logic [CW:0]   cnt_inc;
    logic [CW:0]   idx_inc;
    logic          last_rd;

    // length saturates at the buffer depth
    assign len7     = {1'b0, i_cfg.payload_length};
    assign eff_len  = (len7 > MAX7) ? CW'(MAX_PAYLOAD) : CW'(len7);
    assign store_ok = r_count < eff_len;
    assign do_store = i_cmd.store && store_ok;
    assign cnt_inc  = {1'b0, r_count} + (CW+1)'(1);
    assign idx_inc  = (CW+1)'(r_burst_idx) + (CW+1)'(1);
    assign last_rd  = idx_inc == {1'b0, r_count};

    always_comb begin
        o_sts.start_match = i_rx_byte == i_cfg.start_byte;
        o_sts.addr_match  = i_rx_byte == i_cfg.own_address;
        o_sts.sum_match   = i_rx_byte == r_sum;
        o_sts.len_zero    = eff_len == '0;
        o_sts.data_done   = !store_ok || (cnt_inc >= {1'b0, eff_len});
        o_sts.count_zero  = r_count == '0;
        o_sts.last_rd     = last_rd;
        o_sts.out_free    = !r_out_valid || i_res_ready;
    end

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_mem[r_count[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_burst_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_burst_idx <= '0;
        end else begin
            if (i_cmd.frame_start) begin
                r_sum   <= i_rx_byte;
                r_count <= '0;
            end else if (do_store) begin
                r_sum   <= r_sum + i_rx_byte;
                r_count <= cnt_inc[CW-1:0];
            end else if (i_cmd.clr_frame) begin
                r_sum   <= '0;
                r_count <= '0;
            end
            if (i_cmd.burst_start) begin
                r_burst_idx <= '0;
            end else if (i_cmd.load_byte) begin
                r_burst_idx <= r_burst_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_byte || i_cmd.load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_payload <= r_rd_data;
            r_index   <= 5'(r_burst_idx);
            r_last    <= last_rd;
            r_status  <= ST_OK;
        end else if (i_cmd.load_err) begin
            r_payload <= 8'd0;
            r_index   <= 5'd0;
            r_last    <= 1'b1;
            r_status  <= ST_ERR;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_payload_byte = r_payload;
    assign o_byte_index   = r_index;
    assign o_last         = r_last;
    assign o_status       = r_status;

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_ERR) |-> (r_last && r_payload == 8'd0 && r_index == 5'd0))
        else $error("error result with bad fields");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PAYLOAD))
        else $error("byte count beyond buffer depth");

    a_store_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_store |=> r_count == $past(cnt_inc[CW-1:0]))
        else $error("stored byte not counted");

endmodule

`default_nettype wire

@@ design/afr_ctrl.sv @@
// controller: frame parsing and burst sequencing state machine
`default_nettype none

module afr_ctrl
    import afr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_rx_valid,
    input  wire t_sts i_sts,
    output logic      o_rx_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_ADDR,
        S_DATA,
        S_CSUM,
        S_RD,
        S_LOAD,
        S_ERR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   rx_fire;

    assign o_rx_ready = (r_state == S_HUNT) || (r_state == S_ADDR) ||
                        (r_state == S_DATA) || (r_state == S_CSUM);
    assign rx_fire    = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (rx_fire && i_sts.start_match) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                if (rx_fire) begin
                    if (i_sts.addr_match) begin
                        o_cmd.frame_start = 1'b1;
                        n_state = i_sts.len_zero ? S_CSUM : S_DATA;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_DATA: begin
                if (rx_fire) begin
                    o_cmd.store = 1'b1;
                    if (i_sts.data_done) begin
                        n_state = S_CSUM;
                    end
                end
            end
            S_CSUM: begin
                if (rx_fire) begin
                    if (!i_sts.sum_match) begin
                        n_state = S_ERR;
                    end else if (i_sts.count_zero) begin
                        o_cmd.clr_frame = 1'b1;
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.burst_start = 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    if (i_sts.last_rd) begin
                        o_cmd.clr_frame = 1'b1;
                        n_state = S_HUNT;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_err  = 1'b1;
                    o_cmd.clr_frame = 1'b1;
                    n_state = S_HUNT;
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_byte || o_cmd.load_err) |-> i_sts.out_free)
        else $error("result register overwritten");

    a_no_rx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_LOAD || r_state == S_ERR) |-> !o_rx_ready)
        else $error("receive open during burst");

    a_rd_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_LOAD))
        else $error("buffer read not followed by load");

endmodule

`default_nettype wire
